FILE: design/gsa_pkg.sv
// Shared types and constants of the mixture statistics accumulator.
`default_nettype none

package gsa_pkg;

  // Transaction commands.
  typedef enum logic [2:0] {
    CMD_ACCUM = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_READ  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_SCALE = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_RANGE    = 2'd1,
    STS_INACTIVE = 2'd2
  } status_e;

  // Table selected for a scale sweep.
  typedef enum logic [1:0] {
    TAB_OCC  = 2'd0,
    TAB_MEAN = 2'd1,
    TAB_SQ   = 2'd2
  } tab_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NCOMP = 2'd0;
  localparam logic [1:0] CFG_NDIM  = 2'd1;
  localparam logic [1:0] CFG_MEANS = 2'd2;
  localparam logic [1:0] CFG_VARS  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [8:0] NCOMP_RESET = 9'd256;
  localparam logic [6:0] NDIM_RESET  = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic sweep;
    tab_e tab;
    logic mul;
    logic mul2;
    logic wr_item;
    logic clr_occ;
    logic clr_mean;
    logic clr_sq;
    logic sc_mag;
    logic sc_lo;
    logic sc_hi;
    logic sc_sum;
    logic sc_wr;
    logic res_load;
  } ctrl_t;

  // Decoded status of the held transaction.
  typedef struct packed {
    logic       is_item;
    logic       is_clear;
    logic       is_scale;
    logic       range_err;
    logic       sel_err;
    logic [2:0] sel;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/gsa_if.sv
// Request and response channel interfaces of the statistics accumulator.
`default_nettype none

interface gsa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [7:0]         comp;
  logic [5:0]         elem;
  logic signed [15:0] sample;
  logic [15:0]        weight;
  logic signed [47:0] occ_stat;
  logic signed [47:0] mean_stat;
  logic signed [63:0] sq_stat;
  logic [2:0]         select_mask;
  logic [23:0]        factor;

  modport source (
    output valid, cmd, comp, elem, sample, weight, occ_stat, mean_stat, sq_stat,
           select_mask, factor,
    input  ready
  );
  modport sink (
    input  valid, cmd, comp, elem, sample, weight, occ_stat, mean_stat, sq_stat,
           select_mask, factor,
    output ready
  );
endinterface

interface gsa_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [47:0] occupancy;
  logic signed [47:0] mean_sum;
  logic signed [63:0] square_sum;

  modport source (
    output valid, status, occupancy, mean_sum, square_sum,
    input  ready
  );
  modport sink (
    input  valid, status, occupancy, mean_sum, square_sum,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/gmm_stats_accumulator_unit.sv
// Top level of the diagonal mixture sufficient-statistics accumulator.
//
// Requests arrive on req_i (valid/ready); each transaction yields exactly one
// response on rsp_o. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i; any write empties all three tables with a sweep over all
// MAX_COMPONENTS*MAX_DIM entries, during which req_i.ready stays low.
// Reset runs the same clearing sweep before the first request is taken.
// Accumulate, add and read pass from acceptance to a valid response through
// decode and table read, second multiply, read-modify-write and result.
// A new request is accepted only once the block is back in idle.
// Clear walks the tables at one entry per cycle. Scale walks each selected
// table entry by entry through the read, magnitude, two 32x24 partial
// products, rounding sum and saturating write-back of one shared scaler.
// One transaction is worked on at a time. A finished response waits in the
// output register while the next request is accepted; if the receiver stalls,
// the block holds the following response until the register frees.
`default_nettype none

module gmm_stats_accumulator_unit #(
  parameter int MAX_COMPONENTS = 256,
  parameter int MAX_DIM        = 64
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [gsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [gsa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  gsa_in_if.sink                            req_i,
  gsa_out_if.source                         rsp_o
);

  localparam int DEPTH  = MAX_COMPONENTS * MAX_DIM;
  localparam int TAB_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gsa_pkg::ctrl_t    ctrl;
  gsa_pkg::stat_t    stat;
  logic [TAB_AW-1:0] sweep_addr;
  logic              in_ready;
  logic              out_valid;

  // Sequencing.
  gsa_ctrl #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .MAX_DIM       (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .sweep_addr_o(sweep_addr)
  );

  // Tables and arithmetic.
  gsa_datapath #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .MAX_DIM       (MAX_DIM)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (req_i.cmd),
    .comp_i       (req_i.comp),
    .elem_i       (req_i.elem),
    .sample_i     (req_i.sample),
    .weight_i     (req_i.weight),
    .occ_stat_i   (req_i.occ_stat),
    .mean_stat_i  (req_i.mean_stat),
    .sq_stat_i    (req_i.sq_stat),
    .select_mask_i(req_i.select_mask),
    .factor_i     (req_i.factor),
    .ctrl_i       (ctrl),
    .sweep_addr_i (sweep_addr),
    .stat_o       (stat),
    .status_o     (rsp_o.status),
    .occupancy_o  (rsp_o.occupancy),
    .mean_sum_o   (rsp_o.mean_sum),
    .square_sum_o (rsp_o.square_sum)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

`default_nettype wire

FILE: design/gsa_datapath.sv
// Datapath: configuration, tables, multipliers, scaler and result register.
`default_nettype none

module gsa_datapath #(
  parameter int MAX_COMPONENTS = 256,
  parameter int MAX_DIM        = 64,
  localparam int DEPTH  = MAX_COMPONENTS * MAX_DIM,
  localparam int TAB_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int OCC_AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [gsa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [gsa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire [2:0]                        cmd_i,
  input  wire [7:0]                        comp_i,
  input  wire [5:0]                        elem_i,
  input  wire signed [15:0]                sample_i,
  input  wire [15:0]                       weight_i,
  input  wire signed [47:0]                occ_stat_i,
  input  wire signed [47:0]                mean_stat_i,
  input  wire signed [63:0]                sq_stat_i,
  input  wire [2:0]                        select_mask_i,
  input  wire [23:0]                       factor_i,
  input  gsa_pkg::ctrl_t                   ctrl_i,
  input  wire [TAB_AW-1:0]                 sweep_addr_i,
  output gsa_pkg::stat_t                   stat_o,
  output logic [1:0]                       status_o,
  output logic signed [47:0]               occupancy_o,
  output logic signed [47:0]               mean_sum_o,
  output logic signed [63:0]               square_sum_o
);

  // Saturating additions at the table widths.
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return s[47:0];
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  logic [8:0] num_comp_q;
  logic [6:0] feat_dim_q;
  logic       track_means_q;
  logic       track_vars_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_comp_q    <= gsa_pkg::NCOMP_RESET;
      feat_dim_q    <= gsa_pkg::NDIM_RESET;
      track_means_q <= 1'b1;
      track_vars_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsa_pkg::CFG_NCOMP: num_comp_q    <= cfg_data_i;
        gsa_pkg::CFG_NDIM:  feat_dim_q    <= cfg_data_i[6:0];
        gsa_pkg::CFG_MEANS: track_means_q <= cfg_data_i[0];
        gsa_pkg::CFG_VARS:  track_vars_q  <= cfg_data_i[0];
        default:            num_comp_q    <= num_comp_q;
      endcase
    end
  end

  logic [2:0]         cmd_q;
  logic [7:0]         comp_q;
  logic [5:0]         elem_q;
  logic signed [15:0] sample_q;
  logic [15:0]        weight_q;
  logic [47:0]        occ_stat_q;
  logic [47:0]        mean_stat_q;
  logic [63:0]        sq_stat_q;
  logic [2:0]         sel_q;
  logic [23:0]        factor_q;

  // Transaction holding register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q       <= cmd_i;
      comp_q      <= comp_i;
      elem_q      <= elem_i;
      sample_q    <= sample_i;
      weight_q    <= weight_i;
      occ_stat_q  <= occ_stat_i;
      mean_stat_q <= mean_stat_i;
      sq_stat_q   <= sq_stat_i;
      sel_q       <= select_mask_i;
      factor_q    <= factor_i;
    end
  end

  // Decode and range checks of the held transaction.
  logic means_on, vars_on, comp_ok, elem_ok, range_err, sel_err;
  logic is_accum, is_add, is_read, is_item, is_clear, is_scale;
  logic item_wr_ok;
  logic [TAB_AW-1:0] item_addr;
  logic [OCC_AW-1:0] occ_item_addr;

  assign means_on  = track_means_q;
  assign vars_on   = track_means_q & track_vars_q;
  assign comp_ok   = ({1'b0, comp_q} < num_comp_q) && (32'(comp_q) < MAX_COMPONENTS);
  assign elem_ok   = ({1'b0, elem_q} < feat_dim_q) && (32'(elem_q) < MAX_DIM);
  assign range_err = !(comp_ok && elem_ok);
  assign sel_err   = (sel_q[1] & ~means_on) | (sel_q[2] & ~vars_on);
  assign is_accum  = (cmd_q == gsa_pkg::CMD_ACCUM);
  assign is_add    = (cmd_q == gsa_pkg::CMD_ADD);
  assign is_read   = (cmd_q == gsa_pkg::CMD_READ);
  assign is_item   = is_accum | is_add | is_read;
  assign is_clear  = (cmd_q == gsa_pkg::CMD_CLEAR);
  assign is_scale  = (cmd_q == gsa_pkg::CMD_SCALE);
  assign item_wr_ok = (is_accum | is_add) & ~range_err;
  assign item_addr     = TAB_AW'(32'(comp_q) * MAX_DIM + 32'(elem_q));
  assign occ_item_addr = OCC_AW'(comp_q);

  assign stat_o = '{is_item:   is_item,
                    is_clear:  is_clear,
                    is_scale:  is_scale,
                    range_err: range_err,
                    sel_err:   sel_err,
                    sel:       sel_q};

  // Products for accumulation: w*x, then w*x*x.
  logic signed [32:0] wx_q;
  logic signed [48:0] wxx_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      wx_q <= $signed({1'b0, weight_q}) * sample_q;
    end
    if (ctrl_i.mul2) begin
      wxx_q <= wx_q * sample_q;
    end
  end

  // Tables and their registered read ports.
  logic [47:0] occ_mem  [MAX_COMPONENTS];
  logic [47:0] mean_mem [DEPTH];
  logic [63:0] sq_mem   [DEPTH];
  logic [47:0] occ_rd_q, mean_rd_q;
  logic [63:0] sq_rd_q;
  logic [TAB_AW-1:0] tab_addr;
  logic [OCC_AW-1:0] occ_addr;

  assign tab_addr = ctrl_i.sweep ? sweep_addr_i : item_addr;
  assign occ_addr = ctrl_i.sweep ? sweep_addr_i[OCC_AW-1:0] : occ_item_addr;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      occ_rd_q  <= occ_mem[occ_addr];
      mean_rd_q <= mean_mem[tab_addr];
      sq_rd_q   <= sq_mem[tab_addr];
    end
  end

  // Saturating sums for accumulate and add.
  logic [47:0] occ_add, mean_add, occ_sum, mean_sum;
  logic [63:0] sq_add, sq_sum;

  assign occ_add  = is_accum ? {32'd0, weight_q} : occ_stat_q;
  assign mean_add = is_accum ? {{15{wx_q[32]}}, wx_q} : mean_stat_q;
  assign sq_add   = is_accum ? {{15{wxx_q[48]}}, wxx_q} : sq_stat_q;
  assign occ_sum  = sat_add48(occ_rd_q, occ_add);
  assign mean_sum = sat_add48(mean_rd_q, mean_add);
  assign sq_sum   = sat_add64(sq_rd_q, sq_add);

  // Scaler: magnitude, two partial products, rounding sum, saturation.
  logic [63:0] sc_src;
  logic        neg_q;
  logic [63:0] mag_q;
  logic [55:0] plo_q, phi_q;
  logic        ovf_q;
  logic [63:0] r_q;
  logic [56:0] lo_rnd;
  logic [63:0] top, lim, r_sat, sc_res;

  always_comb begin
    unique case (ctrl_i.tab)
      gsa_pkg::TAB_OCC:  sc_src = {{16{occ_rd_q[47]}}, occ_rd_q};
      gsa_pkg::TAB_MEAN: sc_src = {{16{mean_rd_q[47]}}, mean_rd_q};
      default:           sc_src = sq_rd_q;
    endcase
  end

  assign lo_rnd = {1'b0, plo_q} + 57'h8000;
  assign top    = (ctrl_i.tab == gsa_pkg::TAB_SQ) ? {1'b1, 63'd0} : {16'd0, 1'b1, 47'd0};
  assign lim    = neg_q ? top : (top - 64'd1);
  assign r_sat  = (ovf_q || (r_q > lim)) ? lim : r_q;
  assign sc_res = neg_q ? (64'd0 - r_sat) : r_sat;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sc_mag) begin
      neg_q <= sc_src[63];
      mag_q <= sc_src[63] ? (64'd0 - sc_src) : sc_src;
    end
    if (ctrl_i.sc_lo) begin
      plo_q <= mag_q[31:0] * factor_q;
    end
    if (ctrl_i.sc_hi) begin
      phi_q <= mag_q[63:32] * factor_q;
    end
    if (ctrl_i.sc_sum) begin
      ovf_q <= |phi_q[55:47];
      r_q   <= {1'b0, phi_q[46:0], 16'd0} + {23'd0, lo_rnd[56:16]};
    end
  end

  // Table write ports.
  logic        occ_we, mean_we, sq_we;
  logic [47:0] occ_wdata, mean_wdata;
  logic [63:0] sq_wdata;

  assign occ_we  = (ctrl_i.wr_item & item_wr_ok & (elem_q == 6'd0)) | ctrl_i.clr_occ |
                   (ctrl_i.sc_wr & (ctrl_i.tab == gsa_pkg::TAB_OCC));
  assign mean_we = (ctrl_i.wr_item & item_wr_ok & means_on) | ctrl_i.clr_mean |
                   (ctrl_i.sc_wr & (ctrl_i.tab == gsa_pkg::TAB_MEAN));
  assign sq_we   = (ctrl_i.wr_item & item_wr_ok & vars_on) | ctrl_i.clr_sq |
                   (ctrl_i.sc_wr & (ctrl_i.tab == gsa_pkg::TAB_SQ));

  always_comb begin
    priority if (ctrl_i.wr_item) begin
      occ_wdata  = occ_sum;
      mean_wdata = mean_sum;
      sq_wdata   = sq_sum;
    end else if (ctrl_i.sc_wr) begin
      occ_wdata  = sc_res[47:0];
      mean_wdata = sc_res[47:0];
      sq_wdata   = sc_res;
    end else begin
      occ_wdata  = 48'd0;
      mean_wdata = 48'd0;
      sq_wdata   = 64'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_addr] <= occ_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[tab_addr] <= mean_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_we) begin
      sq_mem[tab_addr] <= sq_wdata;
    end
  end

  // Result register.
  logic read_ok;
  assign read_ok = is_read & ~range_err;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      if (is_item && range_err) begin
        status_o <= gsa_pkg::STS_RANGE;
      end else if ((is_clear || is_scale) && sel_err) begin
        status_o <= gsa_pkg::STS_INACTIVE;
      end else begin
        status_o <= gsa_pkg::STS_OK;
      end
      occupancy_o  <= read_ok ? occ_rd_q : 48'd0;
      mean_sum_o   <= (read_ok && means_on) ? mean_rd_q : 48'd0;
      square_sum_o <= (read_ok && vars_on) ? sq_rd_q : 64'd0;
    end
  end

endmodule

`default_nettype wire

FILE: design/gsa_ctrl.sv
// Controller: sequencing of transactions, clear sweeps and scale sweeps.
`default_nettype none

module gsa_ctrl #(
  parameter int MAX_COMPONENTS = 256,
  parameter int MAX_DIM        = 64,
  localparam int DEPTH  = MAX_COMPONENTS * MAX_DIM,
  localparam int TAB_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  gsa_pkg::stat_t    stat_i,
  output gsa_pkg::ctrl_t    ctrl_o,
  output logic [TAB_AW-1:0] sweep_addr_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECODE = 12'b0000_0000_0010,
    S_ITEM2  = 12'b0000_0000_0100,
    S_ITEM3  = 12'b0000_0000_1000,
    S_DONE   = 12'b0000_0001_0000,
    S_CLEAR  = 12'b0000_0010_0000,
    S_SC_RD  = 12'b0000_0100_0000,
    S_SC_MAG = 12'b0000_1000_0000,
    S_SC_LO  = 12'b0001_0000_0000,
    S_SC_HI  = 12'b0010_0000_0000,
    S_SC_SUM = 12'b0100_0000_0000,
    S_SC_WR  = 12'b1000_0000_0000
  } state_e;

  localparam logic [TAB_AW-1:0] LAST_TAB = TAB_AW'(DEPTH - 1);
  localparam logic [TAB_AW-1:0] LAST_OCC = TAB_AW'(MAX_COMPONENTS - 1);

  state_e            state_q, state_d;
  logic [TAB_AW-1:0] cnt_q, cnt_d;
  logic [2:0]        clr_mask_q, clr_mask_d;
  logic              clr_cmd_q, clr_cmd_d;
  logic [2:0]        sc_mask_q, sc_mask_d;
  logic              out_valid_q, out_valid_d;

  // Current scale table is the lowest selected one.
  gsa_pkg::tab_e     tab;
  logic [2:0]        low_bit;
  logic [TAB_AW-1:0] cur_last;
  logic              occ_in_range;

  always_comb begin
    priority if (sc_mask_q[0]) begin
      tab = gsa_pkg::TAB_OCC;
    end else if (sc_mask_q[1]) begin
      tab = gsa_pkg::TAB_MEAN;
    end else begin
      tab = gsa_pkg::TAB_SQ;
    end
  end

  assign low_bit      = sc_mask_q & (~sc_mask_q + 3'd1);
  assign cur_last     = (tab == gsa_pkg::TAB_OCC) ? LAST_OCC : LAST_TAB;
  assign occ_in_range = 32'(cnt_q) < MAX_COMPONENTS;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_mask_d  = clr_mask_q;
    clr_cmd_d   = clr_cmd_q;
    sc_mask_d   = sc_mask_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    ctrl_o.tab  = tab;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl_o.rd  = 1'b1;
        ctrl_o.mul = 1'b1;
        if (stat_i.is_item) begin
          state_d = S_ITEM2;
        end else if ((stat_i.is_clear || stat_i.is_scale) && !stat_i.sel_err &&
                     (stat_i.sel != 3'd0)) begin
          cnt_d = '0;
          if (stat_i.is_clear) begin
            clr_mask_d = stat_i.sel;
            clr_cmd_d  = 1'b1;
            state_d    = S_CLEAR;
          end else begin
            sc_mask_d = stat_i.sel;
            state_d   = S_SC_RD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_ITEM2: begin
        ctrl_o.mul2 = 1'b1;
        state_d     = S_ITEM3;
      end
      S_ITEM3: begin
        ctrl_o.wr_item = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.res_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_CLEAR: begin
        ctrl_o.sweep    = 1'b1;
        ctrl_o.clr_occ  = clr_mask_q[0] & occ_in_range;
        ctrl_o.clr_mean = clr_mask_q[1];
        ctrl_o.clr_sq   = clr_mask_q[2];
        if (cnt_q == LAST_TAB) begin
          cnt_d   = '0;
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end else begin
          cnt_d = cnt_q + TAB_AW'(1);
        end
      end
      S_SC_RD: begin
        ctrl_o.sweep = 1'b1;
        ctrl_o.rd    = 1'b1;
        state_d      = S_SC_MAG;
      end
      S_SC_MAG: begin
        ctrl_o.sc_mag = 1'b1;
        state_d       = S_SC_LO;
      end
      S_SC_LO: begin
        ctrl_o.sc_lo = 1'b1;
        state_d      = S_SC_HI;
      end
      S_SC_HI: begin
        ctrl_o.sc_hi = 1'b1;
        state_d      = S_SC_SUM;
      end
      S_SC_SUM: begin
        ctrl_o.sc_sum = 1'b1;
        state_d       = S_SC_WR;
      end
      S_SC_WR: begin
        ctrl_o.sweep = 1'b1;
        ctrl_o.sc_wr = 1'b1;
        if (cnt_q == cur_last) begin
          cnt_d     = '0;
          sc_mask_d = sc_mask_q & ~low_bit;
          state_d   = ((sc_mask_q & ~low_bit) == 3'd0) ? S_DONE : S_SC_RD;
        end else begin
          cnt_d   = cnt_q + TAB_AW'(1);
          state_d = S_SC_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A configuration write empties all tables.
    if (cfg_we_i) begin
      state_d    = S_CLEAR;
      cnt_d      = '0;
      clr_mask_d = 3'b111;
      clr_cmd_d  = 1'b0;
    end
  end

  // Control registers; reset starts a full clear sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      clr_mask_q  <= 3'b111;
      clr_cmd_q   <= 1'b0;
      sc_mask_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_mask_q  <= clr_mask_d;
      clr_cmd_q   <= clr_cmd_d;
      sc_mask_q   <= sc_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sweep_addr_o = cnt_q;

endmodule

`default_nettype wire
